/* sv/cartesian_polar_converter_core_macros.svh */
// Assertion macros for the cartesian/polar converter.
// Used by the top level; expects clk and rst_n in scope.
`ifndef CARTESIAN_POLAR_CONVERTER_CORE_MACROS_SVH
`define CARTESIAN_POLAR_CONVERTER_CORE_MACROS_SVH

// same-cycle implication, disabled in reset
`define CCP_ASSERT_SAME(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled in reset
`define CCP_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* sv/ccp_pkg.sv */
// Shared constants, types and the arctangent table of the converter.
// No dependencies; used by all converter modules.
`default_nettype none

package ccp_pkg;

  localparam int FRAC_BITS     = 16;
  localparam int CORDIC_STAGES = 24;
  localparam int SQ_DIGITS     = 33;  // root bits of a 66-bit radicand
  localparam int SIDX_W        = 5;   // CORDIC step index

  localparam int IN_W  = 192;
  localparam int OUT_W = 200;

  localparam logic [63:0] RAD_TO_TURN = 64'h28BE60DB9391054A;
  localparam logic [63:0] DEG_TO_TURN = 64'd51240955760304310;
  localparam logic [31:0] TWO_PI_Q29  = 32'hC90FDAA2;
  localparam logic [8:0]  DEG_FULL    = 9'd360;
  localparam logic signed [63:0] INV_GAIN_Q30 = 64'sd652032874;

  localparam logic CMD_POLAR = 1'b0;
  localparam logic CMD_CART  = 1'b1;

  localparam logic MODE_VEC = 1'b0;
  localparam logic MODE_ROT = 1'b1;

  localparam logic CFG_DEG  = 1'b0;
  localparam logic CFG_WRAP = 1'b1;

  typedef struct packed {
    logic              mode;
    logic signed [63:0] x;
    logic signed [63:0] y;
    logic [31:0]        z;
  } cordic_t;

  typedef struct packed {
    logic [65:0] n;
    logic [34:0] rem;
    logic [32:0] root;
  } sqrt_t;

  // atan(2^-i) in units of 2^-32 turn
  function automatic logic [31:0] atan_turn(input logic [SIDX_W-1:0] idx);
    logic [31:0] v;
    case (idx)
      5'd0:  v = 32'h20000000;
      5'd1:  v = 32'h12E4051E;
      5'd2:  v = 32'h09FB385B;
      5'd3:  v = 32'h051111D4;
      5'd4:  v = 32'h028B0D43;
      5'd5:  v = 32'h0145D7E1;
      5'd6:  v = 32'h00A2F61E;
      5'd7:  v = 32'h00517C55;
      5'd8:  v = 32'h0028BE53;
      5'd9:  v = 32'h00145F2F;
      5'd10: v = 32'h000A2F98;
      5'd11: v = 32'h000517CC;
      5'd12: v = 32'h00028BE6;
      5'd13: v = 32'h000145F3;
      5'd14: v = 32'h0000A2FA;
      5'd15: v = 32'h0000517D;
      5'd16: v = 32'h000028BE;
      5'd17: v = 32'h0000145F;
      5'd18: v = 32'h00000A30;
      5'd19: v = 32'h00000518;
      5'd20: v = 32'h0000028C;
      5'd21: v = 32'h00000146;
      5'd22: v = 32'h000000A3;
      5'd23: v = 32'h00000051;
      5'd24: v = 32'h00000029;
      5'd25: v = 32'h00000014;
      5'd26: v = 32'h0000000A;
      5'd27: v = 32'h00000005;
      5'd28: v = 32'h00000003;
      5'd29: v = 32'h00000001;
      5'd30: v = 32'h00000001;
      default: v = 32'h00000000;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

/* sv/ccp_cordic_cell.sv */
// One CORDIC micro-rotation step, registered; vectoring or rotation per word.
// Depends on ccp_pkg.
`default_nettype none

module ccp_cordic_cell (
  input  logic                         clk,
  input  logic                         en,
  input  logic [ccp_pkg::SIDX_W-1:0]   stage,
  input  ccp_pkg::cordic_t             cin,
  output ccp_pkg::cordic_t             cout_r
);

  ccp_pkg::cordic_t   cout_nxt;
  logic signed [63:0] xi, yi, xs, ys;
  logic [31:0]        step;
  logic               dn;

  always_comb begin
    xi   = cin.x;
    yi   = cin.y;
    xs   = xi >>> stage;
    ys   = yi >>> stage;
    step = ccp_pkg::atan_turn(stage);
    // rotation drives the residual angle to zero, vectoring drives y to zero
    if (cin.mode == ccp_pkg::MODE_ROT) dn = ~cin.z[31];
    else dn = yi[63];
    cout_nxt.mode = cin.mode;
    if (dn) begin
      cout_nxt.x = xi - ys;
      cout_nxt.y = yi + xs;
      cout_nxt.z = cin.z - step;
    end else begin
      cout_nxt.x = xi + ys;
      cout_nxt.y = yi - xs;
      cout_nxt.z = cin.z + step;
    end
  end

  always_ff @(posedge clk) begin
    if (en) cout_r <= cout_nxt;
  end

endmodule

`default_nettype wire

/* sv/ccp_sqrt_cell.sv */
// One digit of a restoring integer square root, registered.
// Depends on ccp_pkg.
`default_nettype none

module ccp_sqrt_cell (
  input  logic            clk,
  input  logic            en,
  input  ccp_pkg::sqrt_t  cin,
  output ccp_pkg::sqrt_t  cout_r
);

  ccp_pkg::sqrt_t cout_nxt;
  logic [36:0]    rem2, trial, diff;
  logic           ge;

  always_comb begin
    rem2  = {cin.rem, cin.n[65:64]};
    trial = {2'b00, cin.root, 2'b01};
    diff  = rem2 - trial;
    ge    = (rem2 >= trial);
    cout_nxt.n    = {cin.n[63:0], 2'b00};
    cout_nxt.rem  = ge ? diff[34:0] : rem2[34:0];
    cout_nxt.root = {cin.root[31:0], ge};
  end

  always_ff @(posedge clk) begin
    if (en) cout_r <= cout_nxt;
  end

endmodule

`default_nettype wire

/* sv/cartesian_polar_converter_core.sv */
// Depth: 37 pipeline stages plus the output register lie between input accept
// and out_tvalid; the 33-cell square root chain sets the depth.
// Throughput: one word per cycle; a held output stalls the pipe only once the
// last stage is also full.
// Reset (rst_n low, synchronous): pipeline empty, angle unit radians, signed
// half-turn direction range.
`default_nettype none
`include "cartesian_polar_converter_core_macros.svh"

module cartesian_polar_converter_core (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_we,
  input  logic                      cfg_index,
  input  logic                      cfg_data,
  input  logic                      in_tvalid,
  output logic                      in_tready,
  // point_x, point_y, ref_x, ref_y, vector_angle, vector_length
  input  logic [ccp_pkg::IN_W-1:0]  in_tdata,
  // command
  input  logic                      in_tuser,
  output logic                      out_tvalid,
  input  logic                      out_tready,
  // cart_x, cart_y, mid_x, mid_y, magnitude, direction, zero pad
  output logic [ccp_pkg::OUT_W-1:0] out_tdata
);

  localparam int F        = ccp_pkg::FRAC_BITS;
  localparam int CS       = ccp_pkg::CORDIC_STAGES;
  localparam int SQD      = ccp_pkg::SQ_DIGITS;
  localparam int TRIG_END = CS + 7;
  localparam int SQ_END   = SQD + 4;
  localparam int LAT      = (TRIG_END > SQ_END) ? TRIG_END : SQ_END;
  localparam int D_T      = LAT - TRIG_END;
  localparam int D_S      = LAT - SQ_END;

  localparam logic [1:0] TURN_ZERO  = 2'b00;
  localparam logic [1:0] TURN_QUART = 2'b01;
  localparam logic [1:0] TURN_HALF  = 2'b10;
  localparam logic [1:0] TURN_3QUART = 2'b11;

  typedef struct packed {
    logic              cmd;
    logic [31:0]       midx;
    logic [31:0]       midy;
    logic signed [31:0] len;
    logic              neg;
    logic              spec;
    logic [1:0]        sz;
  } side_t;

  typedef struct packed {
    logic [59:0]        m;
    logic signed [63:0] x;
    logic signed [63:0] y;
  } norm_t;

  typedef struct packed {
    logic [31:0] cx;
    logic [31:0] cy;
    logic [31:0] dir;
  } trig_t;

  function automatic norm_t norm_step(input norm_t a, input int s);
    norm_t r;
    r = a;
    if ((a.m >> (60 - s)) == 60'd0) begin
      r.m = a.m << s;
      r.x = a.x <<< s;
      r.y = a.y <<< s;
    end
    return r;
  endfunction

  // control
  logic            deg_r, wrap_r;
  logic [LAT:1]    v_r;
  logic            out_valid_r;
  logic [ccp_pkg::OUT_W-1:0] out_data_r, out_data_nxt;
  logic            en;

  // payload
  side_t               side_r [1:LAT];
  side_t               side_in;
  logic signed [32:0]  s1_dx_r, s1_dy_r;
  logic signed [63:0]  s1_plo_r;
  logic signed [31:0]  s1_a_r;
  logic [64:0]         s2_sqx_r;
  logic signed [32:0]  s2_dy_r;
  logic signed [63:0]  s2_phi_r, s2_plo_r;
  logic [64:0]         s3_sqx_r, s3_sqy_r;
  logic [31:0]         s3_turn_r;
  logic [31:0]         s4_za_r;
  norm_t               nm2_r, nm3_r, nm4_r;
  ccp_pkg::cordic_t    c_r [0:CS];
  ccp_pkg::sqrt_t      s_r [0:SQD];
  logic [64:0]         p1_pd_r;
  logic                p1_tneg_r;
  logic signed [65:0]  p1_px_r, p1_py_r;
  trig_t               p2_r;
  trig_t               trig_fin;
  logic [32:0]         mag_fin;

  // combinational
  logic signed [31:0]  px, py, rx, ry, va, vl;
  logic signed [32:0]  dx_nxt, dy_nxt, sx, sy;
  logic [63:0]         ksel;
  logic signed [64:0]  plo_full, phi_full;
  logic signed [65:0]  sqx_full, sqy_full;
  logic [32:0]         adx, ady;
  norm_t               nm_in, nm5;
  logic                spec_nxt;
  logic [1:0]          sz_nxt;
  side_t               side2_nxt, side4_nxt;
  logic signed [95:0]  prod96;
  logic [31:0]         turn;
  logic                neg_nxt;
  ccp_pkg::cordic_t    c0_nxt;
  logic [31:0]         zf;
  logic [32:0]         t33, tmag;
  logic [64:0]         pd_nxt;
  logic signed [33:0]  x34, y34;
  logic signed [65:0]  px_nxt, py_nxt;
  logic [65:0]         vsum, vmag;
  logic signed [65:0]  rx_sum, ry_sum, rxs, rys;
  trig_t               p2_nxt;
  side_t               so;

  assign en        = ~(v_r[LAT] & out_valid_r & ~out_tready);
  assign in_tready = en;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // ---------------- front end ----------------
  always_comb begin
    px = in_tdata[31:0];
    py = in_tdata[63:32];
    rx = in_tdata[95:64];
    ry = in_tdata[127:96];
    va = in_tdata[159:128];
    vl = in_tdata[191:160];
    dx_nxt = 33'(px) - 33'(rx);
    dy_nxt = 33'(py) - 33'(ry);
    sx = 33'(px) + 33'(rx);
    sy = 33'(py) + 33'(ry);
    ksel = deg_r ? ccp_pkg::DEG_TO_TURN : ccp_pkg::RAD_TO_TURN;
    plo_full = va * $signed({1'b0, ksel[31:0]});
    side_in.cmd  = in_tuser;
    side_in.midx = sx[32:1];
    side_in.midy = sy[32:1];
    side_in.len  = vl;
    side_in.neg  = 1'b0;
    side_in.spec = 1'b0;
    side_in.sz   = TURN_ZERO;
  end

  // stage 2: x square, upper angle product, axis check, first normalize step
  always_comb begin
    sqx_full = s1_dx_r * s1_dx_r;
    phi_full = s1_a_r * $signed({1'b0, ksel[63:32]});
    adx = s1_dx_r[32] ? 33'(-s1_dx_r) : 33'(s1_dx_r);
    ady = s1_dy_r[32] ? 33'(-s1_dy_r) : 33'(s1_dy_r);
    nm_in.m = (adx > ady) ? 60'(adx) : 60'(ady);
    nm_in.x = 64'(s1_dx_r);
    nm_in.y = 64'(s1_dy_r);
    spec_nxt = 1'b0;
    sz_nxt   = TURN_ZERO;
    // differences on an axis get an exact direction
    if (s1_dy_r == 33'sd0) begin
      spec_nxt = 1'b1;
      sz_nxt   = s1_dx_r[32] ? TURN_HALF : TURN_ZERO;
    end else if (s1_dx_r == 33'sd0) begin
      spec_nxt = 1'b1;
      sz_nxt   = s1_dy_r[32] ? TURN_3QUART : TURN_QUART;
    end
    side2_nxt      = side_r[1];
    side2_nxt.spec = spec_nxt;
    side2_nxt.sz   = sz_nxt;
  end

  // stage 3/4: y square, angle to binary turn and quadrant fold
  always_comb begin
    sqy_full = s2_dy_r * s2_dy_r;
    prod96   = (96'(s2_phi_r) <<< 32) + 96'(s2_plo_r);
    turn     = prod96[F+63:F+32];
    neg_nxt  = ($signed(s3_turn_r) > 32'sh40000000) ||
               ($signed(s3_turn_r) < -32'sh40000000);
    side4_nxt     = side_r[3];
    side4_nxt.neg = neg_nxt;
  end

  // stage 5: CORDIC start word
  always_comb begin
    nm5 = norm_step(nm4_r, 1);
    if (side_r[4].cmd == ccp_pkg::CMD_CART) begin
      c0_nxt.mode = ccp_pkg::MODE_ROT;
      c0_nxt.x    = ccp_pkg::INV_GAIN_Q30;
      c0_nxt.y    = 64'sd0;
      c0_nxt.z    = s4_za_r;
    end else begin
      c0_nxt.mode = ccp_pkg::MODE_VEC;
      if (nm5.x[63]) begin
        c0_nxt.x = -nm5.x;
        c0_nxt.y = -nm5.y;
        c0_nxt.z = 32'h80000000;
      end else begin
        c0_nxt.x = nm5.x;
        c0_nxt.y = nm5.y;
        c0_nxt.z = 32'h00000000;
      end
    end
  end

  // ---------------- cell chains ----------------
  for (genvar i = 0; i < CS; i++) begin : g_cordic
    ccp_cordic_cell u_cell (
      .clk    (clk),
      .en     (en),
      .stage  (ccp_pkg::SIDX_W'(i)),
      .cin    (c_r[i]),
      .cout_r (c_r[i+1])
    );
  end

  for (genvar j = 0; j < SQD; j++) begin : g_sqrt
    ccp_sqrt_cell u_cell (
      .clk    (clk),
      .en     (en),
      .cin    (s_r[j]),
      .cout_r (s_r[j+1])
    );
  end

  // ---------------- back end ----------------
  always_comb begin
    so = side_r[CS+5];
    zf = so.spec ? {so.sz, 30'd0} : c_r[CS].z;
    t33 = (wrap_r || zf <= 32'h80000000) ? {1'b0, zf} : {1'b1, zf};
    tmag = t33[32] ? -t33 : t33;
    pd_nxt = deg_r ? 65'(tmag) * 65'(ccp_pkg::DEG_FULL)
                   : 65'(tmag) * 65'(ccp_pkg::TWO_PI_Q29);
    x34 = so.neg ? -c_r[CS].x[33:0] : c_r[CS].x[33:0];
    y34 = so.neg ? -c_r[CS].y[33:0] : c_r[CS].y[33:0];
    px_nxt = so.len * x34;
    py_nxt = so.len * y34;
  end

  always_comb begin
    if (deg_r) begin
      vsum = 66'(p1_pd_r) + (66'd1 << (31 - F));
      vmag = vsum >> (32 - F);
    end else begin
      vsum = 66'(p1_pd_r) + (66'd1 << (60 - F));
      vmag = vsum >> (61 - F);
    end
    if (p1_tneg_r) begin
      p2_nxt.dir = (vmag > 66'h80000000) ? 32'h80000000 : 32'(-vmag);
    end else begin
      p2_nxt.dir = (vmag > 66'h7FFFFFFF) ? 32'h7FFFFFFF : vmag[31:0];
    end
    rx_sum = p1_px_r + (66'sd1 <<< 29);
    ry_sum = p1_py_r + (66'sd1 <<< 29);
    rxs = rx_sum >>> 30;
    rys = ry_sum >>> 30;
    if (rxs > 66'sh7FFFFFFF) p2_nxt.cx = 32'h7FFFFFFF;
    else if (rxs < -66'sh80000000) p2_nxt.cx = 32'h80000000;
    else p2_nxt.cx = rxs[31:0];
    if (rys > 66'sh7FFFFFFF) p2_nxt.cy = 32'h7FFFFFFF;
    else if (rys < -66'sh80000000) p2_nxt.cy = 32'h80000000;
    else p2_nxt.cy = rys[31:0];
  end

  if (D_T == 0) begin : g_tdly0
    assign trig_fin = p2_r;
  end else begin : g_tdly
    trig_t trig_dly_r [1:D_T];
    always_ff @(posedge clk) begin
      if (en) begin
        trig_dly_r[1] <= p2_r;
        for (int k = 2; k <= D_T; k++) trig_dly_r[k] <= trig_dly_r[k-1];
      end
    end
    assign trig_fin = trig_dly_r[D_T];
  end

  if (D_S == 0) begin : g_sdly0
    assign mag_fin = s_r[SQD].root;
  end else begin : g_sdly
    logic [32:0] mag_dly_r [1:D_S];
    always_ff @(posedge clk) begin
      if (en) begin
        mag_dly_r[1] <= s_r[SQD].root;
        for (int k = 2; k <= D_S; k++) mag_dly_r[k] <= mag_dly_r[k-1];
      end
    end
    assign mag_fin = mag_dly_r[D_S];
  end

  always_comb begin
    out_data_nxt = '0;
    if (side_r[LAT].cmd == ccp_pkg::CMD_CART) begin
      out_data_nxt[31:0]  = trig_fin.cx;
      out_data_nxt[63:32] = trig_fin.cy;
    end else begin
      out_data_nxt[95:64]   = side_r[LAT].midx;
      out_data_nxt[127:96]  = side_r[LAT].midy;
      out_data_nxt[161:128] = {1'b0, mag_fin};
      out_data_nxt[193:162] = trig_fin.dir;
    end
  end

  // ---------------- registers ----------------
  always_ff @(posedge clk) begin
    if (en) begin
      side_r[1] <= side_in;
      side_r[2] <= side2_nxt;
      side_r[3] <= side_r[2];
      side_r[4] <= side4_nxt;
      for (int k = 5; k <= LAT; k++) side_r[k] <= side_r[k-1];

      s1_dx_r  <= dx_nxt;
      s1_dy_r  <= dy_nxt;
      s1_plo_r <= plo_full[63:0];
      s1_a_r   <= va;

      s2_sqx_r <= sqx_full[64:0];
      s2_dy_r  <= s1_dy_r;
      s2_phi_r <= phi_full[63:0];
      s2_plo_r <= s1_plo_r;
      nm2_r    <= norm_step(nm_in, 32);

      s3_sqx_r  <= s2_sqx_r;
      s3_sqy_r  <= sqy_full[64:0];
      s3_turn_r <= turn;
      nm3_r     <= norm_step(norm_step(nm2_r, 16), 8);

      s_r[0].n    <= 66'(s3_sqx_r) + 66'(s3_sqy_r);
      s_r[0].rem  <= '0;
      s_r[0].root <= '0;
      s4_za_r     <= neg_nxt ? {~s3_turn_r[31], s3_turn_r[30:0]} : s3_turn_r;
      nm4_r       <= norm_step(norm_step(nm3_r, 4), 2);

      c_r[0] <= c0_nxt;

      p1_pd_r   <= pd_nxt;
      p1_tneg_r <= t33[32];
      p1_px_r   <= px_nxt;
      p1_py_r   <= py_nxt;

      p2_r <= p2_nxt;
    end
    if (v_r[LAT] && en) out_data_r <= out_data_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      deg_r       <= 1'b0;
      wrap_r      <= 1'b0;
      v_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          ccp_pkg::CFG_DEG:  deg_r  <= cfg_data;
          ccp_pkg::CFG_WRAP: wrap_r <= cfg_data;
          default: ;
        endcase
      end
      if (en) v_r <= {v_r[LAT-1:1], in_tvalid};
      if (v_r[LAT] && en) out_valid_r <= 1'b1;
      else if (out_tready) out_valid_r <= 1'b0;
    end
  end

  // ---------------- checks ----------------
  `CCP_ASSERT_NEXT(a_stall_keeps, v_r[LAT] && out_valid_r && !out_tready, v_r[LAT] && out_valid_r, "stalled word dropped")
  `CCP_ASSERT_SAME(a_out_from_pipe, $rose(out_valid_r), $past(v_r[LAT]), "output word without source")
  `CCP_ASSERT_SAME(a_mag_range, out_valid_r, out_data_r[161] == 1'b0, "magnitude beyond root range")

endmodule

`default_nettype wire

/* tb/tb_top.sv */
// Self-checking bench for cartesian_polar_converter_core: random bursts in, random stalls out.
// Holds its own bit-exact predictor of the polar and cartesian paths; needs ccp_pkg.
`timescale 1ns / 100ps
`default_nettype none

module tb_top;

  typedef struct {
    logic        cmd;
    logic [31:0] px, py, rx, ry, ang, len;
  } conv_item_t;

  typedef struct {
    logic [31:0] cx, cy, mx, my;
    logic [33:0] mag;
    logic [31:0] dir;
  } conv_res_t;

  localparam int LATENCY  = 38;
  localparam int WD_LIMIT = 4000;

  localparam logic [31:0] ATAN_TAB [32] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
    32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
    32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
    32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
    32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001,
    32'h00000001, 32'h00000000};

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             cfg_we = 1'b0;
  logic             cfg_index = 1'b0;
  logic             cfg_data = 1'b0;
  logic             in_tvalid = 1'b0;
  logic             in_tready;
  logic [ccp_pkg::IN_W-1:0]  in_tdata = '0;
  logic             in_tuser = 1'b0;
  logic             out_tvalid;
  logic             out_tready = 1'b0;
  logic [ccp_pkg::OUT_W-1:0] out_tdata;

  cartesian_polar_converter_core dut (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
  );

  conv_item_t pending_q[$];
  conv_res_t  expected_q[$];
  bit         deg_mode = 1'b0;
  bit         wrap_mode = 1'b0;
  int         mismatches = 0;
  int         idle_cycles = 0;

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic longint sat32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  // atan2 of the difference as a binary angle (2^-32 turn)
  function automatic logic [31:0] atan2_turn(longint dx, longint dy);
    longint ax, ay, m, x, y, xn;
    int k;
    logic [31:0] z;
    if (dy == 0) return (dx < 0) ? 32'h80000000 : 32'h0;
    if (dx == 0) return (dy > 0) ? 32'h40000000 : 32'hC0000000;
    ax = (dx < 0) ? -dx : dx;
    ay = (dy < 0) ? -dy : dy;
    m = (ax > ay) ? ax : ay;
    k = 0;
    while (m < (64'sd1 <<< 59)) begin
      m = m <<< 1;
      k++;
    end
    x = dx <<< k;
    y = dy <<< k;
    z = 32'h0;
    if (x < 0) begin
      x = -x;
      y = -y;
      z = 32'h80000000;
    end
    for (int i = 0; i < ccp_pkg::CORDIC_STAGES && i < 32; i++) begin
      if (y < 0) begin
        xn = x - (y >>> i); y = y + (x >>> i); z = z - ATAN_TAB[i];
      end else begin
        xn = x + (y >>> i); y = y - (x >>> i); z = z + ATAN_TAB[i];
      end
      x = xn;
    end
    return z;
  endfunction

  function automatic logic [31:0] angle_to_turn(longint a, bit deg);
    logic signed [127:0] p;
    p = 128'(a) * $signed({64'd0, (deg ? ccp_pkg::DEG_TO_TURN : ccp_pkg::RAD_TO_TURN)});
    return p[32+ccp_pkg::FRAC_BITS +: 32];
  endfunction

  function automatic longint turn_to_unit(longint t, bit deg);
    logic [127:0] mag, v;
    mag = (t < 0) ? 128'(-t) : 128'(t);
    if (deg) v = (mag * 360 + (128'd1 << (31 - ccp_pkg::FRAC_BITS)))
                 >> (32 - ccp_pkg::FRAC_BITS);
    else     v = (mag * ccp_pkg::TWO_PI_Q29 + (128'd1 << (60 - ccp_pkg::FRAC_BITS)))
                 >> (61 - ccp_pkg::FRAC_BITS);
    return sat32((t < 0) ? -longint'(v[63:0]) : longint'(v[63:0]));
  endfunction

  function automatic conv_res_t convert(conv_item_t it);
    conv_res_t r;
    longint px, py, rx, ry, dx, dy, t, a, x, y, xn, ln;
    logic [65:0] sq, c2;
    logic [32:0] root, c;
    logic [31:0] z;
    bit neg;
    r = '{default: '0};
    if (it.cmd == ccp_pkg::CMD_POLAR) begin
      px = longint'($signed(it.px)); py = longint'($signed(it.py));
      rx = longint'($signed(it.rx)); ry = longint'($signed(it.ry));
      dx = px - rx;
      dy = py - ry;
      sq = 66'((dx < 0) ? -dx : dx) * 66'((dx < 0) ? -dx : dx)
         + 66'((dy < 0) ? -dy : dy) * 66'((dy < 0) ? -dy : dy);
      root = '0;
      for (int b = 32; b >= 0; b--) begin
        c = root | (33'd1 << b);
        c2 = 66'(c) * 66'(c);
        if (c2 <= sq) root = c;
      end
      r.mag = (root > 33'h1FFFFFFFF) ? 34'h3FFFFFFFF : 34'(root);
      z = atan2_turn(dx, dy);
      if (wrap_mode) t = longint'(z);
      else t = (z > 32'h80000000) ? longint'(z) - 64'sd4294967296 : longint'(z);
      r.mx = 32'((px + rx) >>> 1);
      r.my = 32'((py + ry) >>> 1);
      r.dir = 32'(turn_to_unit(t, deg_mode));
    end else begin
      ln = longint'($signed(it.len));
      a = longint'($signed(angle_to_turn(longint'($signed(it.ang)), deg_mode)));
      x = ccp_pkg::INV_GAIN_Q30;
      y = 0;
      neg = 1'b0;
      // fold into the right half-plane, negate at the end
      if (a > 64'sh40000000) begin
        a -= 64'sh80000000; neg = 1'b1;
      end else if (a < -64'sh40000000) begin
        a += 64'sh80000000; neg = 1'b1;
      end
      for (int i = 0; i < ccp_pkg::CORDIC_STAGES && i < 32; i++) begin
        if (a >= 0) begin
          xn = x - (y >>> i); y = y + (x >>> i); a -= longint'(ATAN_TAB[i]);
        end else begin
          xn = x + (y >>> i); y = y - (x >>> i); a += longint'(ATAN_TAB[i]);
        end
        x = xn;
      end
      if (neg) begin
        x = -x;
        y = -y;
      end
      r.cx = 32'(sat32((ln * x + (64'sd1 <<< 29)) >>> 30));
      r.cy = 32'(sat32((ln * y + (64'sd1 <<< 29)) >>> 30));
    end
    return r;
  endfunction

  task automatic report(string field, logic [33:0] got, logic [33:0] want);
    $display("%0t: %s got %h want %h", $realtime, field, got, want);
    mismatches++;
  endtask

  // driver: bursts of random length, random gaps between them
  conv_item_t cur_item;
  int burst_left = 0;
  int gap_left = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) expected_q.push_back(convert(cur_item));
      if (!in_tvalid || in_tready) begin
        if (gap_left > 0) begin
          gap_left--;
          in_tvalid <= 1'b0;
        end else if (pending_q.size() > 0) begin
          cur_item = pending_q.pop_front();
          in_tdata <= {cur_item.len, cur_item.ang, cur_item.ry, cur_item.rx,
                       cur_item.py, cur_item.px};
          in_tuser <= cur_item.cmd;
          in_tvalid <= 1'b1;
          if (burst_left == 0) burst_left = $urandom_range(1, 24);
          burst_left--;
          if (burst_left == 0 && $urandom_range(0, 3) != 0) gap_left = $urandom_range(1, 7);
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // monitor: stall pattern repeats per window of stall_phase; one quarter of each window stalls at random
  logic [6:0] stall_phase = '0;
  conv_res_t want;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      stall_phase <= stall_phase + 7'd1;
      out_tready <= (stall_phase[6:5] == 2'b10) ? ($urandom_range(0, 2) == 0) : 1'b1;
      if (out_tvalid && out_tready) begin
        if (expected_q.size() == 0) begin
          report("unexpected word", 34'(out_tdata[31:0]), '0);
        end else begin
          want = expected_q.pop_front();
          if (out_tdata[31:0] !== want.cx) report("cart_x", 34'(out_tdata[31:0]), 34'(want.cx));
          if (out_tdata[63:32] !== want.cy) report("cart_y", 34'(out_tdata[63:32]), 34'(want.cy));
          if (out_tdata[95:64] !== want.mx) report("mid_x", 34'(out_tdata[95:64]), 34'(want.mx));
          if (out_tdata[127:96] !== want.my)
            report("mid_y", 34'(out_tdata[127:96]), 34'(want.my));
          if (out_tdata[161:128] !== want.mag) report("magnitude", out_tdata[161:128], want.mag);
          if (out_tdata[193:162] !== want.dir)
            report("direction", 34'(out_tdata[193:162]), 34'(want.dir));
        end
      end
    end
  end

  // watchdog: cycles with work outstanding but no word moving
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (pending_q.size() == 0 && expected_q.size() == 0 && !in_tvalid)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WD_LIMIT) begin
        $display("Mismatches found");
        $finish;
      end
    end
  end

  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 5))
      0: return 32'h80000000;
      1: return 32'h7FFFFFFF;
      2: return 32'($signed($urandom_range(0, 32'h3FFFFF)) - 32'sh1FFFFF);
      3: return 32'($urandom_range(0, 4));
      default: return $urandom;
    endcase
  endfunction

  function automatic conv_item_t rand_item();
    conv_item_t it;
    it.cmd = 1'($urandom_range(0, 1));
    it.px = pick_value(); it.py = pick_value();
    it.rx = pick_value(); it.ry = pick_value();
    it.len = pick_value();
    it.ang = ($urandom_range(0, 3) == 0) ? 32'($urandom_range(0, 8)) * 32'h5A0000 : pick_value();
    // axis-aligned and coincident differences, and a zero reference x
    case ($urandom_range(0, 7))
      0: it.ry = it.py;
      1: it.rx = it.px;
      2: begin it.rx = it.px; it.ry = it.py; end
      3: it.rx = 32'h0;
      default: ;
    endcase
    return it;
  endfunction

  function automatic conv_item_t mk(logic cmd, logic [31:0] px, logic [31:0] py,
                                    logic [31:0] rx, logic [31:0] ry,
                                    logic [31:0] ang, logic [31:0] len);
    conv_item_t it;
    it.cmd = cmd; it.px = px; it.py = py; it.rx = rx; it.ry = ry; it.ang = ang; it.len = len;
    return it;
  endfunction

  task automatic wait_drained();
    while (pending_q.size() != 0 || in_tvalid || expected_q.size() != 0) @(posedge clk);
    repeat (LATENCY + 8) @(posedge clk);
  endtask

  task automatic set_units(bit deg, bit wrap);
    @(posedge clk);
    cfg_we <= 1'b1; cfg_index <= ccp_pkg::CFG_DEG; cfg_data <= deg;
    @(posedge clk);
    cfg_index <= ccp_pkg::CFG_WRAP; cfg_data <= wrap;
    @(posedge clk);
    cfg_we <= 1'b0;
    deg_mode = deg;
    wrap_mode = wrap;
  endtask

  task automatic push_directed();
    logic [31:0] one;
    one = 32'h10000;
    pending_q.push_back(mk(ccp_pkg::CMD_POLAR, 0, 0, 0, 0, 0, 0));
    pending_q.push_back(mk(ccp_pkg::CMD_POLAR, one, 0, 0, 0, 0, 0));
    pending_q.push_back(mk(ccp_pkg::CMD_POLAR, -one, 0, 0, 0, 0, 0));
    pending_q.push_back(mk(ccp_pkg::CMD_POLAR, 0, one, 0, 0, 0, 0));
    pending_q.push_back(mk(ccp_pkg::CMD_POLAR, 0, -one, 0, 0, 0, 0));
    pending_q.push_back(mk(ccp_pkg::CMD_POLAR, -one, -1, 0, 0, 0, 0));
    pending_q.push_back(mk(ccp_pkg::CMD_POLAR, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h80000000,
                           32'h80000000, 0, 0));
    pending_q.push_back(mk(ccp_pkg::CMD_POLAR, 32'h80000000, 32'h80000000, 32'h7FFFFFFF,
                           32'h7FFFFFFF, 0, 0));
    pending_q.push_back(mk(ccp_pkg::CMD_POLAR, 32'h7FFFFFFF, 5, 32'h7FFFFFFF, 5, 0, 0));
    pending_q.push_back(mk(ccp_pkg::CMD_POLAR, 3 * one, 4 * one, one, one, 0, 0));
    pending_q.push_back(mk(ccp_pkg::CMD_CART, 0, 0, 0, 0, 0, one));
    pending_q.push_back(mk(ccp_pkg::CMD_CART, 0, 0, 0, 0, 32'h5A0000, one));
    pending_q.push_back(mk(ccp_pkg::CMD_CART, 0, 0, 0, 0, 32'h7FFFFFFF, 32'h7FFFFFFF));
    pending_q.push_back(mk(ccp_pkg::CMD_CART, 0, 0, 0, 0, 32'h80000000, 32'h80000000));
    pending_q.push_back(mk(ccp_pkg::CMD_CART, 0, 0, 0, 0, 32'h3243F, 32'h80000000));
    pending_q.push_back(mk(ccp_pkg::CMD_CART, 0, 0, 0, 0, -32'h5A0000, 32'h7FFFFFFF));
    pending_q.push_back(mk(ccp_pkg::CMD_CART, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF,
                           32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF));
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    for (int ph = 0; ph < 4; ph++) begin
      // radians/signed, degrees/signed, degrees/wrapped, radians/wrapped
      set_units(ph == 1 || ph == 2, ph >= 2);
      push_directed();
      for (int n = 0; n < 120; n++) pending_q.push_back(rand_item());
      wait_drained();
      for (int n = 0; n < 120; n++) pending_q.push_back(rand_item());
      wait_drained();
    end
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

`default_nettype wire
